FILE: rtl/hst_pkg.sv
// ----------------------------------------------------------------------------
// hst_pkg
// Shared types and constants for the handle slot table.
// ----------------------------------------------------------------------------
package hst_pkg;

  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned HANDLE_W   = 32;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned SLOT_IDX_W = 4;
  localparam int unsigned OCC_W      = 5;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ATTACH = 2'd0,
    FUNC_DETACH = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_FIND   = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOSPACE   = 2'd1,
    STATUS_BADHANDLE = 2'd2
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_e;

endpackage

FILE: rtl/hst_req_if.sv
// ----------------------------------------------------------------------------
// hst_req_if
// Request channel: operation and handle, valid/ready handshake.
// ----------------------------------------------------------------------------
interface hst_req_if
  import hst_pkg::*;
();

  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [HANDLE_W-1:0] handle;

  modport source (output valid, output func, output handle, input ready);
  modport sink   (input valid, input func, input handle, output ready);

endinterface

FILE: rtl/hst_rsp_if.sv
// ----------------------------------------------------------------------------
// hst_rsp_if
// Response channel: status, found flag, slot index and occupancy.
// ----------------------------------------------------------------------------
interface hst_rsp_if
  import hst_pkg::*;
();

  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic                  found;
  logic [SLOT_IDX_W-1:0] slot_index;
  logic [OCC_W-1:0]      occupied;

  modport source (output valid, output status, output found, output slot_index,
                  output occupied, input ready);
  modport sink   (input valid, input status, input found, input slot_index,
                  input occupied, output ready);

endinterface

FILE: rtl/hst_cell.sv
// ----------------------------------------------------------------------------
// hst_cell
// One slot of the rotating ring; takes its neighbor's handle on each shift.
// ----------------------------------------------------------------------------
module hst_cell #(
  parameter int unsigned WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             shift_i,
  input  logic [WIDTH-1:0] next_i,
  output logic [WIDTH-1:0] val_o
);

  logic [WIDTH-1:0] val_q;
  logic [WIDTH-1:0] val_d;

  assign val_d = shift_i ? next_i : val_q;
  assign val_o = val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
    end else begin
      val_q <= val_d;
    end
  end

endmodule

FILE: rtl/handle_slot_table.sv
// ----------------------------------------------------------------------------
// handle_slot_table
// Fixed table of handle slots with attach, detach, clear-all and find.
// ----------------------------------------------------------------------------
// The slots form a ring of cells that rotates by one position per cycle,
// while a scan runs and its final turn is not held, past a single compare and
// write point at cell 0. A transaction is accepted while the block is idle,
// then the ring turns SLOTS times, which brings every slot past the compare
// point in ascending order and restores the alignment; the response is
// registered on the last turn. A new request may be accepted while the
// previous response still waits to be taken; the final turn holds if the
// response register is still occupied.
// ----------------------------------------------------------------------------
module handle_slot_table
  import hst_pkg::*;
#(
  parameter int unsigned SLOTS       = 16,
  parameter int unsigned HANDLE_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  hst_req_if.sink   req_i,
  hst_rsp_if.source rsp_o
);

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CntW = $clog2(SLOTS + 1);

  state_e                 state_q, state_d;
  func_e                  op_q, op_d;
  logic [HANDLE_BITS-1:0] key_q, key_d;
  logic [IdxW-1:0]        scan_q, scan_d;
  logic                   hit_q, hit_d;
  logic [IdxW-1:0]        idx_q, idx_d;
  logic [CntW-1:0]        count_q, count_d;

  logic                   rsp_valid_q, rsp_valid_d;
  status_e                status_q, status_d;
  logic                   found_q, found_d;
  logic [SLOT_IDX_W-1:0]  slot_q, slot_d;
  logic [OCC_W-1:0]       occ_q, occ_d;

  logic [HANDLE_BITS-1:0] ring_val [SLOTS];
  logic [HANDLE_BITS-1:0] tail_in;
  logic                   shift;
  logic                   last;
  logic                   can_finish;
  logic                   head_match;
  logic                   first_hit;
  logic                   wr_ok;
  logic                   key_zero;
  logic                   full;
  logic [HANDLE_BITS-1:0] match_key;
  logic                   req_fire;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    logic [HANDLE_BITS-1:0] next_val;
    if (i == SLOTS - 1) begin : g_tail
      assign next_val = tail_in;
    end else begin : g_mid
      assign next_val = ring_val[i+1];
    end
    hst_cell #(
      .WIDTH (HANDLE_BITS)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .next_i  (next_val),
      .val_o   (ring_val[i])
    );
  end

  assign req_i.ready      = (state_q == ST_IDLE);
  assign req_fire         = req_i.valid && req_i.ready;
  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.status     = status_q;
  assign rsp_o.found      = found_q;
  assign rsp_o.slot_index = slot_q;
  assign rsp_o.occupied   = occ_q;

  assign key_zero   = (key_q == '0);
  assign full       = (count_q >= CntW'(SLOTS));
  assign match_key  = (op_q == FUNC_ATTACH) ? '0 : key_q;
  assign head_match = (ring_val[0] == match_key);
  assign first_hit  = head_match && !hit_q;
  assign last       = (scan_q == IdxW'(SLOTS - 1));
  assign can_finish = !rsp_valid_q || rsp_o.ready;
  assign shift      = (state_q == ST_SCAN) && (!last || can_finish);
  assign wr_ok      = ((op_q == FUNC_ATTACH) && !key_zero && !full) ||
                      ((op_q == FUNC_DETACH) && !key_zero);

  always_comb begin
    tail_in = ring_val[0];
    if (op_q == FUNC_CLEAR) begin
      tail_in = '0;
    end else if (first_hit && wr_ok) begin
      tail_in = (op_q == FUNC_ATTACH) ? key_q : '0;
    end
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    key_d       = key_q;
    scan_d      = scan_q;
    hit_d       = hit_q;
    idx_d       = idx_q;
    count_d     = count_q;
    rsp_valid_d = rsp_valid_q;
    status_d    = status_q;
    found_d     = found_q;
    slot_d      = slot_q;
    occ_d       = occ_q;

    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          op_d    = func_e'(req_i.func);
          key_d   = HANDLE_BITS'(req_i.handle);
          scan_d  = '0;
          hit_d   = 1'b0;
          idx_d   = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (shift) begin
          scan_d = scan_q + IdxW'(1);
          if (first_hit) begin
            hit_d = 1'b1;
            idx_d = scan_q;
          end
          if (last) begin
            state_d     = ST_IDLE;
            rsp_valid_d = 1'b1;
            status_d    = STATUS_OK;
            found_d     = 1'b0;
            slot_d      = '0;
            unique case (op_q)
              FUNC_ATTACH: begin
                if (key_zero) begin
                  status_d = STATUS_BADHANDLE;
                end else if (full || !hit_d) begin
                  status_d = STATUS_NOSPACE;
                end else begin
                  slot_d  = SLOT_IDX_W'(idx_d);
                  count_d = count_q + CntW'(1);
                end
              end
              FUNC_DETACH: begin
                if (key_zero || !hit_d) begin
                  status_d = STATUS_BADHANDLE;
                end else begin
                  slot_d = SLOT_IDX_W'(idx_d);
                  if (count_q != '0) begin
                    count_d = count_q - CntW'(1);
                  end
                end
              end
              FUNC_CLEAR: begin
                count_d = '0;
              end
              FUNC_FIND: begin
                if (hit_d) begin
                  found_d = 1'b1;
                  slot_d  = SLOT_IDX_W'(idx_d);
                end else begin
                  status_d = STATUS_BADHANDLE;
                end
              end
              default: begin
                status_d = STATUS_BADHANDLE;
              end
            endcase
            occ_d = OCC_W'(count_d);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      scan_q      <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
      hit_q       <= hit_d;
      scan_q      <= scan_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    key_q    <= key_d;
    idx_q    <= idx_d;
    status_q <= status_d;
    found_q  <= found_d;
    slot_q   <= slot_d;
    occ_q    <= occ_d;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(SLOTS))
    else $error("occupancy count exceeds slot count");

  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> (state_q == ST_SCAN) && (scan_q == '0) && !hit_q)
    else $error("accepted transaction did not start a scan");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && found_q) |-> (status_q == STATUS_OK))
    else $error("found flag set on a failed response");

  a_resp_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(rsp_valid_q)) |-> (state_q == ST_IDLE) && $past(last))
    else $error("response raised before the ring completed a turn");
`endif

endmodule
